// ----- rtl/abd_pkg.sv -----
package abd_pkg;

  // Mixing table geometry
  localparam int unsigned TblDepth = 256;
  localparam int unsigned TblAw    = 8;
  localparam int unsigned WordW    = 32;

  // Table generator: x = (x * 125 + 3) mod 0x2AAAAB
  localparam int unsigned LcgW = 22;
  localparam int unsigned AccW = 29;
  localparam logic [LcgW-1:0] LcgSeed = 22'h100001;
  localparam logic [LcgW-1:0] LcgMod  = 22'h2AAAAB;
  localparam logic [6:0]      LcgMul  = 7'd125;
  localparam logic [1:0]      LcgInc  = 2'd3;

  // Quotient estimate: 3 * mod is 2^23 + 1, so (3 * acc) >> 23 is q or q + 1
  localparam int unsigned LcgQSh = 23;
  localparam int unsigned QW     = 8;

  // Generator sequencing: ten values per table index, bank four holds the last two
  localparam logic [3:0] HiStep    = 4'd8;
  localparam logic [3:0] LastStep  = 4'd9;
  localparam logic [1:0] PhMul     = 2'd0;
  localparam logic [1:0] PhQuot    = 2'd1;
  localparam logic [1:0] LastPhase = 2'd2;
  localparam logic [TblAw-1:0] LastIdx = 8'hFF;

  // Cipher constants
  localparam logic [WordW-1:0] MixInit = 32'hEEEEEEEE;
  localparam logic [WordW-1:0] KeyAdd  = 32'h11111111;
  localparam logic [1:0]       MixInc  = 2'd3;

  // Table write request from the fill sequencer
  typedef struct packed {
    logic             we;
    logic [TblAw-1:0] addr;
    logic [WordW-1:0] data;
  } tbl_wr_t;

  // Running key step
  function automatic logic [WordW-1:0] key_step(input logic [WordW-1:0] key);
    key_step = (key >> 11) | ((~key << 21) + KeyAdd);
  endfunction

endpackage

// ----- rtl/abd_table_fill.sv -----
module abd_table_fill (
  input  logic             clk,
  input  logic             rst_n,
  output abd_pkg::tbl_wr_t wr,
  output logic             busy
);

  logic                         busy_r;
  logic [abd_pkg::TblAw-1:0]    idx_r;
  logic [3:0]                   step_r;
  logic [1:0]                   ph_r;
  logic [abd_pkg::LcgW-1:0]     x_r;
  logic [abd_pkg::AccW-1:0]     acc_r;
  logic [abd_pkg::AccW-1:0]     qm_r;
  logic [15:0]                  hi_r;

  logic [abd_pkg::AccW-1:0]     acc_nxt;
  logic [abd_pkg::AccW+1:0]     acc_x3;
  logic [abd_pkg::QW-1:0]       q_est;
  logic [abd_pkg::AccW-1:0]     qm_nxt;
  logic [abd_pkg::AccW-1:0]     diff;
  logic [abd_pkg::AccW-1:0]     red;
  logic                         step_done;

  // Multiply, estimate the quotient, then subtract and correct by one modulus
  always_comb begin
    acc_nxt = abd_pkg::AccW'(x_r) * abd_pkg::AccW'(abd_pkg::LcgMul)
            + abd_pkg::AccW'(abd_pkg::LcgInc);
    acc_x3  = {1'b0, acc_r, 1'b0} + {2'b00, acc_r};
    q_est   = acc_x3[abd_pkg::AccW+1:abd_pkg::LcgQSh];
    qm_nxt  = abd_pkg::AccW'(q_est) * abd_pkg::AccW'(abd_pkg::LcgMod);
    diff    = acc_r - qm_r;
    red     = (acc_r < qm_r) ? (diff + abd_pkg::AccW'(abd_pkg::LcgMod)) : diff;
    step_done = busy_r && (ph_r == abd_pkg::LastPhase);
  end

  // Write bank-four word once its low half is known
  always_comb begin
    wr.we   = step_done && (step_r == abd_pkg::LastStep);
    wr.addr = idx_r;
    wr.data = {hi_r, red[15:0]};
    busy    = busy_r;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= '0;
      ph_r   <= abd_pkg::PhMul;
      x_r    <= abd_pkg::LcgSeed;
    end else if (busy_r) begin
      if (step_done) begin
        ph_r <= abd_pkg::PhMul;
        x_r  <= red[abd_pkg::LcgW-1:0];
        if (step_r == abd_pkg::LastStep) begin
          step_r <= '0;
          idx_r  <= idx_r + 8'd1;
          if (idx_r == abd_pkg::LastIdx) begin
            busy_r <= 1'b0;
          end
        end else begin
          step_r <= step_r + 4'd1;
        end
      end else begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  // Hold working values
  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (ph_r == abd_pkg::PhMul) begin
        acc_r <= acc_nxt;
      end
      if (ph_r == abd_pkg::PhQuot) begin
        qm_r <= qm_nxt;
      end
      if (step_done && (step_r == abd_pkg::HiStep)) begin
        hi_r <= red[15:0];
      end
    end
  end

endmodule

// ----- rtl/archive_block_decrypt.sv -----
// Block decryptor for a stream of 32-bit words.
// Input channel: in_valid / in_stall carry in_cipher_word, in_block_key and
// in_last_word. The first item after reset, and the item after one flagged
// with in_last_word, opens a block and loads its key from in_block_key;
// in_block_key is ignored on every other item.
// Result channel: out_valid / out_stall carry out_plain_word and
// out_block_end, one result per item, in order.
// Latency: an item is registered in the key stage, then in the result stage.
// Throughput: one item per cycle while out_stall is low; the mixing word
// update closes within the cycle after the table read, and the 256x32 table
// memory serves one read per cycle.
// Reset: a generator rebuilds the mixing table in the memory, taking each
// sequence value through multiply, quotient estimate, correction; ten values
// per entry; in_stall stays high until it is done. Key and block state clear.
// Stall: while out_stall holds a result, one more item may be accepted into
// the stage behind it; after that in_stall rises until the result is taken.
// The table is read-only after the rebuild, so reads never meet a write.
module archive_block_decrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_cipher_word,
  input  logic [31:0] in_block_key,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_plain_word,
  output logic        out_block_end
);

  abd_pkg::tbl_wr_t              tbl_wr;
  logic                          fill_busy;

  logic [abd_pkg::WordW-1:0]     tbl_mem [abd_pkg::TblDepth];
  logic [abd_pkg::WordW-1:0]     rd_data_r;
  logic                          rd_en;
  logic [abd_pkg::TblAw-1:0]     rd_addr;

  logic                          block_open_r;
  logic [abd_pkg::WordW-1:0]     key_r;
  logic [abd_pkg::WordW-1:0]     key_nxt;
  logic [abd_pkg::WordW-1:0]     mix_r;
  logic [abd_pkg::WordW-1:0]     mix_nxt;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [abd_pkg::WordW-1:0]     s1_cw_r;
  logic [abd_pkg::WordW-1:0]     s1_key_r;
  logic                          s1_last_r;
  logic                          s1_start_r;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [abd_pkg::WordW-1:0]     out_plain_r;
  logic                          out_end_r;

  logic                          in_acc;
  logic                          s1_adv;
  logic [abd_pkg::WordW-1:0]     cur_key;
  logic [abd_pkg::WordW-1:0]     mix_in;
  logic [abd_pkg::WordW-1:0]     mix_a;
  logic [abd_pkg::WordW-1:0]     plain;

  abd_table_fill u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tbl_wr),
    .busy  (fill_busy)
  );

  // Table memory: written by the rebuild, read once per accepted item
  always_ff @(posedge clk) begin
    if (tbl_wr.we) begin
      tbl_mem[tbl_wr.addr] <= tbl_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[rd_addr];
    end
  end

  // Handshake and key stage
  always_comb begin
    s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall = fill_busy || (s1_valid_r && !s1_adv);
    in_acc   = in_valid && !in_stall;
    cur_key  = block_open_r ? key_r : in_block_key;
    key_nxt  = abd_pkg::key_step(cur_key);
    rd_en    = in_acc;
    rd_addr  = cur_key[abd_pkg::TblAw-1:0];
  end

  // Mix stage: combine table word, decrypt, fold plain word back in
  always_comb begin
    mix_in  = s1_start_r ? abd_pkg::MixInit : mix_r;
    mix_a   = mix_in + rd_data_r;
    plain   = s1_cw_r ^ (mix_a + s1_key_r);
    mix_nxt = mix_a + plain + (mix_a << 5) + abd_pkg::WordW'(abd_pkg::MixInc);
  end

  // Next valid flags
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_open_r <= 1'b0;
      key_r        <= '0;
      mix_r        <= abd_pkg::MixInit;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        block_open_r <= !in_last_word;
        key_r        <= key_nxt;
      end
      if (s1_adv) begin
        mix_r <= mix_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cw_r    <= in_cipher_word;
      s1_key_r   <= cur_key;
      s1_last_r  <= in_last_word;
      s1_start_r <= !block_open_r;
    end
    if (s1_adv) begin
      out_plain_r <= plain;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_word = out_plain_r;
  assign out_block_end  = out_end_r;

endmodule

// ----- rtl/abd_port_checker.sv -----
module abd_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_plain_word,
  input logic        out_block_end
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plain_word)
      && $stable(out_block_end))
    else $error("stalled result changed");

  // Reset starts the table rebuild, so no item is taken
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A fresh result rises only after a matching accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching item");

endmodule

bind archive_block_decrypt abd_port_checker u_abd_port_checker (.*);
